### src/bemf_zero_cross_commutator_defines.svh
// assertion macros used by the back-emf commutator rtl
`ifndef BEMF_ZERO_CROSS_COMMUTATOR_DEFINES_SVH
`define BEMF_ZERO_CROSS_COMMUTATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property checked on every clock outside reset
`define BZC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// antecedent in one cycle, consequent in the next
`define BZC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BZC_ASSERT(lbl, prop, msg)
`define BZC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### src/bemf_zc_pkg.sv
// types and constants for the back-emf zero-crossing commutator
package bemf_zc_pkg;

  localparam int unsigned AdcBits   = 12;
  localparam int unsigned CountBits = 16;
  localparam int unsigned StepBits  = 3;
  localparam int unsigned SlopeBits = 8;
  localparam int unsigned ShiftBits = 4;
  localparam int unsigned CfgIdxBits = 2;

  localparam logic [ShiftBits-1:0] DecayShiftRst = ShiftBits'(3);
  localparam logic [SlopeBits-1:0] SlopeMinRst   = SlopeBits'(2);
  localparam logic [AdcBits-1:0]   OffRefRst     = AdcBits'(8);

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_DECAY_SHIFT = 2'd0,
    CFG_SLOPE_MIN   = 2'd1,
    CFG_OFF_REF     = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [ShiftBits-1:0] decay_shift;
    logic [SlopeBits-1:0] slope_min;
    logic [AdcBits-1:0]   off_ref;
  } cfg_t;

  typedef struct packed {
    logic [StepBits-1:0] step_number;
    logic [AdcBits-1:0]  bus_voltage;
    logic [AdcBits-1:0]  bemf_sample;
    logic                pwm_on;
  } smp_t;

  typedef struct packed {
    logic [StepBits-1:0] next_step;
    logic                crossing_detected;
  } res_t;

endpackage

### src/bemf_zc_core.sv
// per-sample tracking state, slope qualification and commutation timing
`include "bemf_zero_cross_commutator_defines.svh"

module bemf_zc_core import bemf_zc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fire_i,
  input  smp_t smp_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  localparam int unsigned ThrBits = CountBits + 2;

  logic [StepBits-1:0]  tracked_q, tracked_d;
  logic [AdcBits-1:0]   prev_q, prev_d;
  logic [SlopeBits-1:0] slope_q, slope_d;
  logic [CountBits-1:0] samples_q, samples_d;
  logic [CountBits-1:0] ctime_q, ctime_d;
  logic [CountBits-1:0] last_len_q, last_len_d;
  logic                 pend_q, pend_d;
  logic [StepBits-1:0]  emitted_q, emitted_d;

  logic [StepBits-1:0]  idx;
  logic                 step_chg;
  logic [AdcBits-1:0]   bus_ref, guard, half;
  logic                 falling, mono, past_half, hit, latch;
  logic [SlopeBits-1:0] slope_inc;
  logic [CountBits-1:0] ctime_l;
  logic                 pend_l;
  logic [ThrBits-1:0]   thr;
  logic                 due, emit;

  assign idx      = smp_i.step_number - StepBits'(1);
  assign step_chg = idx != tracked_q;
  assign bus_ref  = smp_i.pwm_on ? smp_i.bus_voltage : cfg_i.off_ref;
  assign guard    = bus_ref >> cfg_i.decay_shift;
  assign half     = bus_ref >> 1;
  assign falling  = ~smp_i.step_number[0];

  always_comb begin
    if (falling) begin
      mono      = (!smp_i.pwm_on || smp_i.bemf_sample > guard) && prev_q > smp_i.bemf_sample;
      past_half = smp_i.bemf_sample < half;
    end else begin
      mono      = (!smp_i.pwm_on || smp_i.bemf_sample < (bus_ref - guard))
                  && prev_q < smp_i.bemf_sample;
      past_half = smp_i.bemf_sample > half;
    end
  end

  assign slope_inc = (slope_q != '1) ? slope_q + SlopeBits'(1) : slope_q;
  assign hit       = mono && slope_inc >= cfg_i.slope_min && past_half;
  assign latch     = hit && ctime_q == '0;
  assign ctime_l   = latch ? samples_q : ctime_q;
  assign pend_l    = pend_q | latch;

  // delay of 3/8 of the previous step, no wrap
  assign thr  = ThrBits'(ctime_l) + ThrBits'(last_len_q >> 2) + ThrBits'(last_len_q >> 3);
  assign due  = pend_l && ThrBits'(samples_q) >= thr;
  assign emit = due && emitted_q != smp_i.step_number;

  always_comb begin
    tracked_d  = tracked_q;
    prev_d     = prev_q;
    slope_d    = slope_q;
    samples_d  = samples_q;
    ctime_d    = ctime_q;
    last_len_d = last_len_q;
    pend_d     = pend_q;
    emitted_d  = emitted_q;
    if (fire_i) begin
      if (step_chg) begin
        tracked_d  = idx;
        last_len_d = samples_q;
        samples_d  = '0;
        slope_d    = '0;
        ctime_d    = '0;
        pend_d     = 1'b0;
      end else begin
        slope_d = mono ? slope_inc : '0;
        prev_d  = smp_i.bemf_sample;
        ctime_d = ctime_l;
        pend_d  = pend_l && !due;
        if (emit) begin
          emitted_d = smp_i.step_number;
          ctime_d   = '0;
        end else if (samples_q != '1) begin
          samples_d = samples_q + CountBits'(1);
        end
      end
    end
  end

  assign res_o.next_step         = (!step_chg && emit) ? smp_i.step_number : '0;
  assign res_o.crossing_detected = !step_chg && latch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracked_q  <= '0;
      prev_q     <= '0;
      slope_q    <= '0;
      samples_q  <= '0;
      ctime_q    <= '0;
      last_len_q <= '0;
      pend_q     <= 1'b0;
      emitted_q  <= '0;
    end else begin
      tracked_q  <= tracked_d;
      prev_q     <= prev_d;
      slope_q    <= slope_d;
      samples_q  <= samples_d;
      ctime_q    <= ctime_d;
      last_len_q <= last_len_d;
      pend_q     <= pend_d;
      emitted_q  <= emitted_d;
    end
  end

  `BZC_ASSERT_NEXT(a_chg_clears, fire_i && step_chg,
                   slope_q == '0 && samples_q == '0 && !pend_q && ctime_q == '0,
                   "step change did not restart tracking")
  `BZC_ASSERT_NEXT(a_emit_holds_count, fire_i && !step_chg && emit,
                   samples_q == $past(samples_q) && ctime_q == '0,
                   "sample count advanced on a commutation beat")
  `BZC_ASSERT_NEXT(a_emit_records, fire_i && res_o.next_step != '0,
                   emitted_q == $past(smp_i.step_number) && !pend_q,
                   "emitted step not recorded")
  `BZC_ASSERT(a_latch_once, !(res_o.crossing_detected && ctime_q != '0),
              "crossing latched while one is already held")

endmodule

### src/bemf_zero_cross_commutator.sv
// an accepted sample is held in the input register, and its result in the output register, which drives the outputs
// throughput: one sample per cycle unless out_ready_i stalls the output, the tracking state updates in a single pass
// an input register and an output register each accept while their contents move on
// reset clears all tracking state and loads the register defaults 3, 2 and 8
// registers are to be written through the config port only while the block is idle; the block does not enforce this
module bemf_zero_cross_commutator import bemf_zc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [AdcBits-1:0]    cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [StepBits-1:0]   step_number_i,
  input  logic [AdcBits-1:0]    bus_voltage_i,
  input  logic [AdcBits-1:0]    bemf_sample_i,
  input  logic                  pwm_on_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [StepBits-1:0]   next_step_o,
  output logic                  crossing_detected_o
);

  cfg_t cfg_q;
  smp_t s1_q;
  logic s1_valid_q;
  res_t res, out_q;
  logic out_valid_q;
  logic s1_adv, fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decay_shift <= DecayShiftRst;
      cfg_q.slope_min   <= SlopeMinRst;
      cfg_q.off_ref     <= OffRefRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DECAY_SHIFT: cfg_q.decay_shift <= cfg_data_i[ShiftBits-1:0];
        CFG_SLOPE_MIN:   cfg_q.slope_min   <= cfg_data_i[SlopeBits-1:0];
        CFG_OFF_REF:     cfg_q.off_ref     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign fire       = s1_valid_q && s1_adv;
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q.step_number <= step_number_i;
      s1_q.bus_voltage <= bus_voltage_i;
      s1_q.bemf_sample <= bemf_sample_i;
      s1_q.pwm_on      <= pwm_on_i;
    end
  end

  bemf_zc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .smp_i  (s1_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign next_step_o         = out_q.next_step;
  assign crossing_detected_o = out_q.crossing_detected;

endmodule
